/* design/itoa_pkg.sv */
// itoa_pkg: shared types, character constants and the digit-to-ascii function
// for the radix conversion block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // ascii codes
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  // 'a' less ten, so that digit value ten lands on 'a'
  localparam logic [6:0] CHAR_A_OFS = 7'd87;

  // radix limits and the signed base
  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] BASE_MIN    = 6'd2;
  localparam logic [5:0] BASE_MAX    = 6'd36;
  localparam logic [5:0] BASE_DEC    = 6'd10;
  localparam logic [5:0] DIGIT_NINE  = 6'd9;

  // status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // digit value to lowercase ascii
  function automatic logic [6:0] digit_code(input logic [5:0] d);
    logic [6:0] dw;
    dw = {1'b0, d};
    if (d > DIGIT_NINE) begin
      return CHAR_A_OFS + dw;
    end else begin
      return CHAR_ZERO + dw;
    end
  endfunction

endpackage

`default_nettype wire

/* design/itoa_div.sv */
// itoa_div: restoring divider, one quotient bit per cycle, small divisor
// depends on itoa_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module itoa_div
  import itoa_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [5:0]   divisor,
  output logic [W-1:0] quotient,
  output logic [5:0]   remainder,
  output div_stat_t    stat
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  qreg;
  logic [5:0]    acc;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  // one trial subtract per step
  logic [6:0] shifted;
  logic [6:0] diff;
  logic       take;

  always_comb begin
    shifted = {acc, qreg[W-1]};
    diff    = shifted - {1'b0, divisor};
    take    = (shifted >= {1'b0, divisor});
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (busy) begin
      qreg <= {qreg[W-2:0], take};
      acc  <= take ? diff[5:0] : shifted[5:0];
    end else if (start) begin
      qreg <= dividend;
      acc  <= '0;
    end
  end

  assign quotient  = qreg;
  assign remainder = acc;
  assign stat      = '{busy: busy, done: done};

endmodule

`default_nettype wire

/* design/int_to_ascii_radix_unit.sv */
// int_to_ascii_radix_unit: integer to ascii digits in a set radix, signed in base ten
// depends on itoa_pkg and itoa_div
//
//   channel  signals                       direction  word
//   in       in_valid, in_stall, value     to block   one integer
//   out      out_valid, out_stall,         from block one character
//            char_code, last
//   cfg      cfg_write, cfg_data           to block   radix register
//
// each digit is divided out in the shared one-bit-a-step divider, then each
// character is read from the digit memory and loaded into the output register
// in_stall stays high from acceptance until the last character is loaded
// a stall on the output holds the character register and pauses the readout
// synchronous reset sets the radix to ten and empties the output register
`timescale 1ns / 1ps
`default_nettype none

module int_to_ascii_radix_unit
  import itoa_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           char_code,
  output logic                 last,
  input  logic                 cfg_write,
  input  logic [5:0]           cfg_data
);

  localparam int IW = $clog2(WORD_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]           state;
  logic [5:0]           radix;
  logic [5:0]           base;
  logic                 neg;
  logic [WORD_BITS-1:0] mag;
  logic                 div_start;
  logic [IW-1:0]        ndig;
  logic [IW-1:0]        rd_idx;
  logic [5:0]           rd_data;
  logic [5:0]           digit_mem [WORD_BITS];

  logic [WORD_BITS-1:0] quotient;
  logic [5:0]           remainder;
  div_stat_t            div_stat;

  logic                 in_take;
  logic                 out_free;
  logic [5:0]           base_eff;
  logic                 in_neg;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // clamp the radix to the supported range
  always_comb begin
    priority if (radix < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (radix > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = radix;
    end
    in_neg = (base_eff == BASE_DEC) && value[WORD_BITS-1];
  end

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write) begin
      radix <= cfg_data;
    end
  end

  itoa_div #(
    .W (WORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (base),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (div_stat)
  );

  // digit store, least significant first
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_stat.done) begin
      digit_mem[ndig] <= remainder;
    end
    rd_data <= digit_mem[rd_idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (quotient == '0) begin
              state <= neg ? S_SIGN : S_READ;
            end else begin
              div_start <= 1'b1;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= (rd_idx == '0) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          base <= base_eff;
          neg  <= in_neg;
          mag  <= in_neg ? (~value + WORD_BITS'(1)) : value;
          ndig <= '0;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          mag    <= quotient;
          rd_idx <= ndig;
          ndig   <= ndig + IW'(1);
        end
      end
      S_SIGN: begin
        if (out_free) begin
          char_code <= CHAR_MINUS;
          last      <= 1'b0;
        end
      end
      S_READ: begin
      end
      S_LOAD: begin
        if (out_free) begin
          char_code <= digit_code(rd_data);
          last      <= (rd_idx == '0);
          if (rd_idx != '0) begin
            rd_idx <= rd_idx - IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // divider only ever runs while a conversion is dividing
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    (div_stat.busy || div_stat.done) |-> (state == S_DIV))
    else $error("divider active outside the divide phase");

  // loading the final digit ends the word with last set
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && out_free && rd_idx == '0) |=>
      (state == S_IDLE && out_valid && last))
    else $error("final digit did not close the word");

  // every presented character is one of the legal codes
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((char_code == CHAR_MINUS) ||
                   (char_code >= CHAR_ZERO && char_code <= 7'd57) ||
                   (char_code >= 7'd97 && char_code <= 7'd122)))
    else $error("character code out of range");

  // the minus sign never carries last
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == CHAR_MINUS) |-> !last)
    else $error("sign marked as final character");

endmodule

`default_nettype wire

/* sim/int_to_ascii_radix_unit_tb.sv */
// int_to_ascii_radix_unit_tb: self-checking bench for the radix conversion block
// depends on itoa_pkg and int_to_ascii_radix_unit; a queue-fed driver and a checking
// monitor with random idling on both channels and radix changes between phases
`timescale 1ns / 1ps

module int_to_ascii_radix_unit_tb;
  import itoa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [6:0]  ASC_LOWER_A = 7'd97;
  localparam logic [6:0]  DIGIT_TEN   = 7'd10;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [31:0] value     = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  char_code;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [5:0]  cfg_data  = '0;

  logic [31:0] int_backlog [$];
  char_t       chars_due [$];
  logic [5:0]  radix_set = RADIX_RESET;
  logic        calm      = 1'b0;
  int unsigned in_hold   = 0;
  int unsigned out_hold  = 0;
  int unsigned bad_count = 0;
  int unsigned chars_seen = 0;
  int unsigned cycle_count = 0;

  int_to_ascii_radix_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // radix register value to the base actually used
  function automatic logic [31:0] eff_base(input logic [5:0] r);
    if (r < BASE_MIN) begin
      return 32'(BASE_MIN);
    end else if (r > BASE_MAX) begin
      return 32'(BASE_MAX);
    end
    return 32'(r);
  endfunction

  // expected characters of one integer, most significant digit first
  function automatic void spell_int(input logic [31:0] v, input logic [5:0] r);
    logic [31:0] base;
    logic [31:0] mag;
    logic [6:0]  dig [0:31];
    int          nd;
    char_t       c;
    base = eff_base(r);
    mag  = v;
    nd   = 0;
    // signed form only in base ten
    if (base == 32'(BASE_DEC) && v[31]) begin
      mag    = ~v + 32'd1;
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      chars_due.push_back(c);
    end
    while (nd == 0 || mag != 0) begin
      dig[nd] = 7'(mag % base);
      mag     = mag / base;
      nd++;
    end
    for (int k = nd - 1; k >= 0; k--) begin
      if (dig[k] > 7'(DIGIT_NINE)) begin
        c.code = ASC_LOWER_A + dig[k] - DIGIT_TEN;
      end else begin
        c.code = CHAR_ZERO + dig[k];
      end
      c.last = (k == 0);
      chars_due.push_back(c);
    end
  endfunction

  // idle cycles before the next word or output stall cycles, none in calm stretches
  function automatic int unsigned pick_gap();
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // random integer biased towards digit-count boundaries and extremes
  function automatic logic [31:0] pick_value(input logic [5:0] r);
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 7))
      0: return 32'($urandom_range(0, 50));
      1: return -32'($urandom_range(1, 50));
      2: begin
        repeat ($urandom_range(1, 8)) p = p * eff_base(r);
        return p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      3: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      4:       return $urandom >> $urandom_range(0, 31);
      5:       return -($urandom >> $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // input driver: predicts on acceptance, then offers the next word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_hold  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        spell_int(value, radix_set);
      end
      if (!in_valid || !in_stall) begin
        if (in_hold != 0) begin
          in_hold  <= in_hold - 1;
          in_valid <= 1'b0;
        end else if (int_backlog.size() != 0) begin
          value    <= int_backlog.pop_front();
          in_valid <= 1'b1;
          in_hold  <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each accepted character and draws the next stall
  always @(posedge clk) begin
    char_t       want;
    int unsigned nh;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      nh = (out_hold != 0) ? out_hold - 1 : 0;
      if (out_valid && !out_stall) begin
        nh = pick_gap();
        if (chars_due.size() == 0) begin
          if (bad_count < 10) begin
            $display("unexpected char %0d: code %0d last %0b", chars_seen, char_code, last);
          end
          bad_count++;
        end else begin
          want = chars_due.pop_front();
          if (want.code !== char_code || want.last !== last) begin
            if (bad_count < 10) begin
              $display("mismatch at char %0d: expected code %0d last %0b, got code %0d last %0b",
                       chars_seen, want.code, want.last, char_code, last);
            end
            bad_count++;
          end
        end
        chars_seen++;
      end
      out_hold  <= nh;
      out_stall <= (nh != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL int_to_ascii_radix_unit");
      $finish;
    end
  end

  // wait until every word is through and every character has come back
  task automatic drain();
    while (int_backlog.size() != 0 || in_valid || chars_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // radix change, only with the block idle
  task automatic write_radix(input logic [5:0] r);
    drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    cfg_write <= 1'b0;
    radix_set = r;
  endtask

  // stimulus
  initial begin
    logic [5:0] r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset radix of ten: zero, sign, digit wrap, extremes incl. the most negative
    calm = 1'b1;
    int_backlog.push_back(32'd0);
    int_backlog.push_back(32'd1);
    int_backlog.push_back(32'hffff_ffff);
    int_backlog.push_back(32'd9);
    int_backlog.push_back(32'd10);
    int_backlog.push_back(32'h7fff_ffff);
    int_backlog.push_back(32'h8000_0000);
    int_backlog.push_back(-32'd1000);

    // binary: longest outputs, negatives as raw bit patterns
    write_radix(BASE_MIN);
    calm = 1'b0;
    int_backlog.push_back(32'd0);
    int_backlog.push_back(32'hffff_ffff);
    int_backlog.push_back(32'h8000_0000);
    int_backlog.push_back(32'd5);

    // base 36: top digit 'z' and the carry into two digits
    write_radix(BASE_MAX);
    int_backlog.push_back(32'd35);
    int_backlog.push_back(32'd36);
    int_backlog.push_back(32'hffff_ffff);
    int_backlog.push_back(32'h8000_0000);

    // hex with letters, negative unsigned
    write_radix(6'd16);
    int_backlog.push_back(32'hdead_beef);
    int_backlog.push_back(-32'd16);

    // radix below and above range saturates
    write_radix(6'd0);
    int_backlog.push_back(32'd6);
    write_radix(6'd1);
    int_backlog.push_back(32'h8000_0001);
    write_radix(6'd63);
    int_backlog.push_back(32'd1295);
    write_radix(6'd37);
    int_backlog.push_back(32'd36);
    write_radix(BASE_DEC);
    int_backlog.push_back(32'h8000_0000);

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 5))
        0:       r = BASE_DEC;
        1:       r = BASE_MIN;
        2:       r = BASE_MAX;
        default: r = 6'($urandom_range(0, 63));
      endcase
      write_radix(r);
      calm = ($urandom_range(0, 3) == 0);
      repeat (10) int_backlog.push_back(pick_value(r));
    end

    drain();
    repeat (50) @(negedge clk);
    if (bad_count == 0 && chars_due.size() == 0) begin
      $display("PASS int_to_ascii_radix_unit");
    end else begin
      $display("FAIL int_to_ascii_radix_unit");
    end
    $finish;
  end

endmodule
